FILE: sv/plct_pkg.sv
package plct_pkg;

   localparam int MaxPointsDefault    = 16;
   localparam int FractionBitsDefault = 8;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_PUSH   = 2'd1,
      OP_COMMIT = 2'd2,
      OP_APPLY  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_FEW      = 2'd2,
      ST_IDENTITY = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
      logic [4:0]         point_count;
      logic               table_is_valid;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SORT_RD_I,
      S_SORT_CMP,
      S_SORT_SHIFT,
      S_SORT_PLACE,
      S_AP_RD_FIRST,
      S_AP_RD_LAST,
      S_AP_EDGE,
      S_AP_BIS_RD,
      S_AP_BIS_CMP,
      S_AP_SEG_RD_LO,
      S_AP_SEG_RD_HI,
      S_AP_SEG_HI,
      S_AP_MUL,
      S_AP_DIV,
      S_AP_DONE,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

endpackage

FILE: sv/plct_point_ram.sv
module plct_point_ram #(
   parameter int MAX_POINTS = plct_pkg::MaxPointsDefault,
   localparam int AW = $clog2(MAX_POINTS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [63:0]       wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [63:0]       rd_data
);
   import plct_pkg::*;

   logic [63:0] mem_ff [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: sv/plct_divider.sv
module plct_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  plct_pkg::div_req_type div_req,
   output logic                  done,
   output logic [63:0]           quotient
);
   import plct_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = '0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[31:0], quo_ff[63]};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = busy_ff && (cnt_ff == 7'd63);
   assign quotient = {quo_ff[62:0], (trial >= {1'b0, dvs_ff})};

endmodule

FILE: sv/piecewise_linear_calibration_table_core.sv
// Calibration table: clear, push, commit (stable insertion sort) and apply
// (bisection plus linear interpolation, extrapolating from the end segment
// outside the table). One transaction at a time: busy rises the cycle after
// acceptance and falls after the response strobe. Clear and push respond in
// the cycle after acceptance. Commit makes one memory read per compare and
// shift, so it is quickest when the points are already in order and slowest
// when they are in reverse order. Apply runs a bisection search (skipped at
// the ends of the table) and a radix-2 64-step divider; a zero-width segment
// or an uncommitted table answers sooner. The receiver cannot stall:
// rsp_valid is high for exactly one cycle per transaction.
module piecewise_linear_calibration_table_core #(
   parameter int MAX_POINTS    = plct_pkg::MaxPointsDefault,
   localparam int AW = $clog2(MAX_POINTS),
   localparam int CW = $clog2(MAX_POINTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  plct_pkg::req_type req_data,
   output logic              rsp_valid,
   output plct_pkg::rsp_type rsp_data
);
   import plct_pkg::*;

   localparam logic [CW-1:0] MaxCount = CW'(MAX_POINTS);
   localparam logic [CW-1:0] One = CW'(1);
   localparam logic [CW-1:0] Two = CW'(2);

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic        valid_ff, valid_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [63:0] key_ff, key_in;
   logic signed [31:0] xa_ff, xa_in, ya_ff, ya_in, xl_ff, xl_in, yl_ff, yl_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in, dxs_ff, dxs_in;
   logic [63:0] prod_ff, prod_in;
   logic        neg_ff, neg_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, rd_data;
   div_req_type   div_req;
   logic          div_done;
   logic [63:0]   quotient;

   logic signed [31:0] rd_x, rd_y;
   logic [CW-1:0] mid;
   logic signed [34:0] sum;
   logic [32:0] mag_dy, mag_dxs;

   assign rd_x = rd_data[63:32];
   assign rd_y = rd_data[31:0];
   assign mid  = CW'((CW+1)'(lo_ff) + (CW+1)'(hi_ff) >> 1);

   plct_point_ram #(.MAX_POINTS(MAX_POINTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   plct_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      valid_in = valid_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      i_in = i_ff; j_in = j_ff; lo_in = lo_ff; hi_in = hi_ff;
      key_in = key_ff;
      xa_in = xa_ff; ya_in = ya_ff; xl_in = xl_ff; yl_in = yl_ff;
      dx_in = dx_ff; dy_in = dy_ff; dxs_in = dxs_ff;
      prod_in = prod_ff; neg_in = neg_ff;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_addr = '0;
      div_req = '0;
      sum     = '0;
      mag_dy  = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
      mag_dxs = dxs_ff[32] ? 33'(-dxs_ff) : 33'(dxs_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
               unique case (op_type'(req_data.operation))
                  OP_CLEAR: begin
                     count_in = '0;
                     valid_in = 1'b0;
                     state_in = S_RESPOND;
                  end
                  OP_PUSH: begin
                     if (count_ff >= MaxCount) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(count_ff);
                        wr_data  = {req_data.x_value, req_data.y_value};
                        count_in = count_ff + One;
                     end
                     state_in = S_RESPOND;
                  end
                  OP_COMMIT: begin
                     if (count_ff < Two) begin
                        rsp_in.status = ST_FEW;
                        state_in = S_RESPOND;
                     end else begin
                        valid_in = 1'b1;
                        i_in     = One;
                        rd_addr  = AW'(One);
                        state_in = S_SORT_RD_I;
                     end
                  end
                  OP_APPLY: begin
                     if (!valid_ff || count_ff < Two) begin
                        rsp_in.result_value = req_data.x_value;
                        rsp_in.status = ST_IDENTITY;
                        state_in = S_RESPOND;
                     end else begin
                        rd_addr  = '0;
                        state_in = S_AP_RD_FIRST;
                     end
                  end
                  default: state_in = S_RESPOND;
               endcase
            end
         end
         S_SORT_RD_I: begin
            key_in = rd_data;
            j_in   = i_ff;
            rd_addr = AW'(i_ff - One);
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            if ($signed(rd_x) > $signed(key_ff[63:32])) begin
               wr_en   = 1'b1;
               wr_addr = AW'(j_ff);
               wr_data = rd_data;
               j_in    = j_ff - One;
               state_in = S_SORT_SHIFT;
            end else begin
               state_in = S_SORT_PLACE;
            end
         end
         S_SORT_SHIFT: begin
            if (j_ff == '0) begin
               state_in = S_SORT_PLACE;
            end else begin
               rd_addr  = AW'(j_ff - One);
               state_in = S_SORT_CMP;
            end
         end
         S_SORT_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = AW'(j_ff);
            wr_data = key_ff;
            if (i_ff + One >= count_ff) begin
               state_in = S_RESPOND;
            end else begin
               i_in     = i_ff + One;
               rd_addr  = AW'(i_ff + One);
               state_in = S_SORT_RD_I;
            end
         end
         S_AP_RD_FIRST: begin
            xl_in = rd_x;
            yl_in = rd_y;
            rd_addr  = AW'(count_ff - One);
            state_in = S_AP_RD_LAST;
         end
         S_AP_RD_LAST: begin
            xa_in = rd_x;
            ya_in = rd_y;
            state_in = S_AP_EDGE;
         end
         S_AP_EDGE: begin
            if (req_ff.x_value <= xl_ff) begin
               xa_in = xl_ff; ya_in = yl_ff;
               lo_in = '0; hi_in = One;
               rd_addr  = '0;
               state_in = S_AP_SEG_RD_LO;
            end else if (req_ff.x_value >= xa_ff) begin
               lo_in = count_ff - Two; hi_in = count_ff - One;
               rd_addr  = AW'(count_ff - Two);
               state_in = S_AP_SEG_RD_LO;
            end else begin
               lo_in = '0; hi_in = count_ff - One;
               state_in = S_AP_BIS_RD;
            end
         end
         S_AP_BIS_RD: begin
            if (hi_ff - lo_ff > One) begin
               rd_addr  = AW'(mid);
               state_in = S_AP_BIS_CMP;
            end else begin
               rd_addr  = AW'(lo_ff);
               state_in = S_AP_SEG_RD_LO;
            end
         end
         S_AP_BIS_CMP: begin
            if (req_ff.x_value >= rd_x) lo_in = mid;
            else hi_in = mid;
            state_in = S_AP_BIS_RD;
         end
         S_AP_SEG_RD_LO: begin
            xl_in = rd_x;
            yl_in = rd_y;
            if (req_ff.x_value < xa_ff) begin
               xa_in = rd_x; ya_in = rd_y;
            end
            rd_addr  = AW'(hi_ff);
            state_in = S_AP_SEG_RD_HI;
         end
         S_AP_SEG_RD_HI: begin
            dx_in = 33'(rd_x) - 33'(xl_ff);
            dy_in = 33'(rd_y) - 33'(yl_ff);
            state_in = S_AP_SEG_HI;
         end
         S_AP_SEG_HI: begin
            dxs_in = 33'(req_ff.x_value) - 33'(xa_ff);
            if (dx_ff == '0) begin
               rsp_in.result_value = ya_ff;
               state_in = S_RESPOND;
            end else begin
               state_in = S_AP_MUL;
            end
         end
         S_AP_MUL: begin
            neg_in  = (dy_ff[32] != dxs_ff[32]) != dx_ff[32];
            div_req.start    = 1'b1;
            div_req.dividend = 64'(mag_dy[31:0]) * 64'(mag_dxs[31:0]);
            div_req.divisor  = dx_ff[32] ? 32'(-dx_ff) : dx_ff[31:0];
            state_in = S_AP_DIV;
         end
         S_AP_DIV: begin
            if (div_done) begin
               prod_in  = quotient;
               state_in = S_AP_DONE;
            end
         end
         S_AP_DONE: begin
            if (prod_ff > 64'h2_0000_0000) begin
               rsp_in.result_value = neg_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
               sum = neg_ff ? 35'(ya_ff) - 35'(prod_ff[33:0])
                            : 35'(ya_ff) + 35'(prod_ff[33:0]);
               if (sum > 35'sh0_7fff_ffff) rsp_in.result_value = 32'sh7fff_ffff;
               else if (sum < -35'sh0_8000_0000)
                  rsp_in.result_value = 32'sh8000_0000;
               else rsp_in.result_value = sum[31:0];
            end
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      req_ff <= req_in; rsp_ff <= rsp_in;
      i_ff <= i_in; j_ff <= j_in; lo_ff <= lo_in; hi_ff <= hi_in;
      key_ff <= key_in;
      xa_ff <= xa_in; ya_ff <= ya_in; xl_ff <= xl_in; yl_ff <= yl_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dxs_ff <= dxs_in;
      prod_ff <= prod_in; neg_ff <= neg_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESPOND);
   always_comb begin
      rsp_data = rsp_ff;
      rsp_data.point_count    = 5'(count_ff);
      rsp_data.table_is_valid = valid_ff;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transaction not taken");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount) else $error("count overflow");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after response");

endmodule
